### sv/trrd_pkg.sv
// shared types and constants for the tile row run-length decoder
// no dependencies; imported by every module of the block
package trrd_pkg;

  localparam int ROW_WIDTH = 128;
  localparam int COL_W     = ($clog2(ROW_WIDTH) > 7) ? $clog2(ROW_WIDTH) : 7;
  localparam int CNT_W     = 5;   // longest run is 17 tiles

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int SRT_W  = 40;
  localparam int LRT_W  = 24;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_SHORT_LO = 2'd0;
  localparam logic [1:0] REG_SHORT_HI = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;

  localparam logic [SRT_W-1:0] SHORT_LO_RST = 40'h6759510762;
  localparam logic [SRT_W-1:0] SHORT_HI_RST = 40'h4B5E4E216A;
  localparam logic [LRT_W-1:0] LONG_RST     = 24'h5F5200;

  localparam logic [7:0] CODE_SHORT = 8'h80;
  localparam logic [7:0] CODE_LONG  = 8'hD0;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       row_start;
  } code_in_t;

  typedef struct packed {
    logic [7:0] tile_value;
    logic [6:0] column;
    logic       row_end;
    logic       last_of_input;
  } tile_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;       // code byte lands on a full row without row_start
    logic slot_free;  // output register can take a tile
    logic last_tile;  // tile being emitted ends the code byte or the row
  } dp_sts_t;

endpackage

### sv/tile_row_rle_decoder.sv
// top level of the tile row run-length decoder
// depends on trrd_pkg, trrd_regs, trrd_dp, trrd_ctrl
//
//   channel  ports                                  beat
//   in       in_valid, in_stall, in_data            one code byte, row start flag
//   out      out_valid, out_stall, out_data         one tile with column and flags
//   cfg      psel, penable, pwrite, paddr, pwdata,  tile table registers, 64-bit data
//            prdata, pready
//
// a code byte is taken first, then its tiles go one per cycle from the run
// counter into the output register while the output register can take a tile
// a byte dropped on a full row is taken in the idle state and starts no run
// out_stall holds the run; the next byte is taken while the last tile waits
// after reset the row counts as full until a byte with row_start arrives
module tile_row_rle_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  trrd_pkg::code_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output trrd_pkg::tile_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [trrd_pkg::DATA_W-1:0]   pwdata,
  output logic [trrd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import trrd_pkg::*;

  logic [SRT_W-1:0] short_lo;
  logic [SRT_W-1:0] short_hi;
  logic [LRT_W-1:0] long_tiles;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  trrd_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .short_lo   (short_lo),
    .short_hi   (short_hi),
    .long_tiles (long_tiles)
  );

  trrd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .short_lo   (short_lo),
    .short_hi   (short_hi),
    .long_tiles (long_tiles),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  trrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

endmodule

### sv/trrd_regs.sv
// tile table registers behind the apb-style configuration port
// depends on trrd_pkg
module trrd_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [trrd_pkg::DATA_W-1:0]   pwdata,
  output logic [trrd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [trrd_pkg::SRT_W-1:0]    short_lo,
  output logic [trrd_pkg::SRT_W-1:0]    short_hi,
  output logic [trrd_pkg::LRT_W-1:0]    long_tiles
);
  import trrd_pkg::*;

  logic [SRT_W-1:0] short_lo_r;
  logic [SRT_W-1:0] short_hi_r;
  logic [LRT_W-1:0] long_r;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_lo_r <= SHORT_LO_RST;
      short_hi_r <= SHORT_HI_RST;
      long_r     <= LONG_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHORT_LO: short_lo_r <= pwdata[SRT_W-1:0];
        REG_SHORT_HI: short_hi_r <= pwdata[SRT_W-1:0];
        REG_LONG:     long_r     <= pwdata[LRT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHORT_LO: prdata = {{(DATA_W-SRT_W){1'b0}}, short_lo_r};
      REG_SHORT_HI: prdata = {{(DATA_W-SRT_W){1'b0}}, short_hi_r};
      REG_LONG:     prdata = {{(DATA_W-LRT_W){1'b0}}, long_r};
      default:      prdata = '0;
    endcase
  end

  assign short_lo   = short_lo_r;
  assign short_hi   = short_hi_r;
  assign long_tiles = long_r;

endmodule

### sv/trrd_dp.sv
// datapath: code decode, run counter, column counter and output register
// depends on trrd_pkg; driven by trrd_ctrl
module trrd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trrd_pkg::code_in_t          in_data,
  input  logic [trrd_pkg::SRT_W-1:0]  short_lo,
  input  logic [trrd_pkg::SRT_W-1:0]  short_hi,
  input  logic [trrd_pkg::LRT_W-1:0]  long_tiles,
  input  trrd_pkg::dp_cmd_t           cmd,
  output trrd_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output trrd_pkg::tile_out_t         out_data
);
  import trrd_pkg::*;

  logic [7:0]       tile_r, tile_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_done_r, row_done_nxt;
  logic             out_valid_r, out_valid_nxt;
  tile_out_t        out_data_r, out_data_nxt;

  logic [7:0]       code;
  logic [7:0]       dec_tile;
  logic [CNT_W-1:0] dec_count;
  logic [7:0]       short_tile;
  logic [7:0]       long_tile;
  logic             at_end;

  assign code = in_data.code_byte;

  always_comb begin
    unique case (code[6:3])
      4'd0:    short_tile = short_lo[7:0];
      4'd1:    short_tile = short_lo[15:8];
      4'd2:    short_tile = short_lo[23:16];
      4'd3:    short_tile = short_lo[31:24];
      4'd4:    short_tile = short_lo[39:32];
      4'd5:    short_tile = short_hi[7:0];
      4'd6:    short_tile = short_hi[15:8];
      4'd7:    short_tile = short_hi[23:16];
      4'd8:    short_tile = short_hi[31:24];
      default: short_tile = short_hi[39:32];
    endcase
  end

  // long index is bits 5:4 minus one, so codes d0, e0, f0 pick entries 0..2
  always_comb begin
    unique case (code[5:4])
      2'd1:    long_tile = long_tiles[7:0];
      2'd2:    long_tile = long_tiles[15:8];
      default: long_tile = long_tiles[23:16];
    endcase
  end

  always_comb begin
    if (code < CODE_SHORT) begin
      dec_tile  = code;
      dec_count = CNT_W'(1);
    end else if (code < CODE_LONG) begin
      dec_tile  = short_tile;
      dec_count = CNT_W'(code[2:0]) + CNT_W'(2);
    end else begin
      dec_tile  = long_tile;
      dec_count = CNT_W'(code[3:0]) + CNT_W'(2);
    end
  end

  assign at_end = (col_r >= COL_W'(ROW_WIDTH - 1));

  assign sts.skip      = row_done_r & ~in_data.row_start;
  assign sts.slot_free = ~out_valid_r | ~out_stall;
  assign sts.last_tile = (remain_r == CNT_W'(1)) | at_end;

  always_comb begin
    tile_nxt      = tile_r;
    remain_nxt    = remain_r;
    col_nxt       = col_r;
    row_done_nxt  = row_done_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (cmd.load) begin
      tile_nxt   = dec_tile;
      remain_nxt = dec_count;
      if (in_data.row_start) begin
        col_nxt      = '0;
        row_done_nxt = 1'b0;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.tile_value    = tile_r;
      out_data_nxt.column        = col_r[6:0];
      out_data_nxt.row_end       = at_end;
      out_data_nxt.last_of_input = sts.last_tile;
      remain_nxt                 = remain_r - CNT_W'(1);
      if (at_end) begin
        col_nxt      = '0;
        row_done_nxt = 1'b1;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_done_r  <= 1'b1;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
    end else begin
      col_r       <= col_nxt;
      row_done_r  <= row_done_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tile_r     <= tile_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/trrd_ctrl.sv
// controller: takes a code byte, then steps the datapath one tile per beat
// depends on trrd_pkg; commands trrd_dp
module trrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trrd_pkg::dp_sts_t   sts,
  output trrd_pkg::dp_cmd_t   cmd
);
  import trrd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        // a byte that lands on a full row without row_start is dropped here
        if (in_valid && !sts.skip) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.last_tile) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
